>>> rtl/core/infix_to_postfix_converter_defines.svh
// -----------------------------------------------------------------------------
// Infix to postfix converter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle in reset.
// -----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define ITP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ITP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/itp_pkg.sv
// -----------------------------------------------------------------------------
// Infix to postfix converter package
// Token codes, result codes, precedence and the front-to-back command type.
// -----------------------------------------------------------------------------
package itp_pkg;

  // Fixed widths of the word fields
  localparam int unsigned FIELD_VALUE_W = 32;

  // Defaults for the top level parameters
  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Input token types
  localparam logic REQ_OPERAND  = 1'b0;
  localparam logic REQ_OPERATOR = 1'b1;

  // Operator codes
  localparam logic [2:0] OP_MUL   = 3'd0;
  localparam logic [2:0] OP_DIV   = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_SUB   = 3'd3;
  localparam logic [2:0] OP_OPEN  = 3'd4;
  localparam logic [2:0] OP_CLOSE = 3'd5;
  localparam logic [2:0] OP_END   = 3'd6;
  localparam logic [2:0] OP_POW   = 3'd7;

  // Result kinds
  localparam logic [1:0] KIND_OPERAND  = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  // What the back end has to do with a word
  typedef enum logic [2:0] {
    CMD_OPERAND,
    CMD_BINARY,
    CMD_OPEN,
    CMD_CLOSE,
    CMD_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] op;
    logic [1:0] prec;
  } cmd_t;

  // Binding strength; zero for codes that are not binary operators
  function automatic logic [1:0] prec_of(logic [2:0] op);
    logic [1:0] p;
    case (op)
      OP_MUL, OP_DIV: p = 2'd2;
      OP_ADD, OP_SUB: p = 2'd1;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/core/itp_front.sv
// -----------------------------------------------------------------------------
// Infix to postfix converter front end
// Accepts token words and classifies them into back end commands.
// -----------------------------------------------------------------------------
module itp_front #(
  parameter int unsigned DATA_W = 32
) (
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [DATA_W-1:0]          value_i,
  input  logic [2:0]                 op_code_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output itp_pkg::cmd_t              q_cmd_o,
  output logic [DATA_W-1:0]          q_value_o
);
  import itp_pkg::*;

  cmd_kind_e kind;

  always_comb begin
    if (req_type_i == REQ_OPERAND) begin
      kind = CMD_OPERAND;
    end else begin
      case (op_code_i)
        OP_OPEN:  kind = CMD_OPEN;
        OP_CLOSE: kind = CMD_CLOSE;
        OP_END:   kind = CMD_END;
        default:  kind = CMD_BINARY;
      endcase
    end
  end

  assign in_stall_o     = q_full_i;
  assign q_push_o       = in_valid_i && !q_full_i;
  assign q_cmd_o.kind   = kind;
  assign q_cmd_o.op     = op_code_i;
  assign q_cmd_o.prec   = prec_of(op_code_i);
  assign q_value_o      = value_i;

endmodule

>>> rtl/core/itp_queue.sv
// -----------------------------------------------------------------------------
// Infix to postfix converter command queue
// Short FIFO that decouples the classifier from the stack engine.
// -----------------------------------------------------------------------------
module itp_queue #(
  parameter int unsigned DATA_W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  itp_pkg::cmd_t       push_cmd_i,
  input  logic [DATA_W-1:0]   push_value_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output itp_pkg::cmd_t       head_cmd_o,
  output logic [DATA_W-1:0]   head_value_o
);
  import itp_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              cmd_q   [QUEUE_DEPTH];
  logic [DATA_W-1:0] value_q [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]     cnt_q;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == NW'(QUEUE_DEPTH));
  assign valid_o      = (cnt_q != '0);
  assign head_cmd_o   = cmd_q[rd_ptr_q];
  assign head_value_o = value_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && valid_o;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + NW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cmd_q[wr_ptr_q]   <= push_cmd_i;
      value_q[wr_ptr_q] <= push_value_i;
    end
  end

endmodule

>>> rtl/core/itp_back.sv
// -----------------------------------------------------------------------------
// Infix to postfix converter back end
// Operator stack engine: one stack step per cycle into an output register, unless out stall holds it.
// -----------------------------------------------------------------------------
`include "infix_to_postfix_converter_defines.svh"

module itp_back #(
  parameter int unsigned DATA_W      = 32,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  itp_pkg::cmd_t      cmd_i,
  input  logic [DATA_W-1:0]  cmd_value_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         out_kind_o,
  output logic [DATA_W-1:0]  out_value_o,
  output logic [2:0]         out_op_o,
  output logic [1:0]         error_code_o,
  output logic               last_o
);
  import itp_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // top_q is the top of stack, sub_q a registered copy of the entry below it;
  // the memory holds everything under the top.
  logic [2:0]    mem [STACK_DEPTH];
  logic [CW-1:0] count_q, count_d;
  logic [2:0]    top_q, sub_q;

  logic          ovalid_q;
  logic [1:0]    okind_q, oerr_q;
  logic [DATA_W-1:0] ovalue_q;
  logic [2:0]    oop_q;
  logic          olast_q;

  logic          has_top, has_sub, full, out_free;
  logic [1:0]    top_prec, sub_prec;
  logic          emit, do_push, do_pop, done, step_go, load;
  logic [1:0]    res_kind, res_err;
  logic [2:0]    res_op;
  logic          res_last;
  logic [CW-1:0] wr_addr, rd_addr;
  logic          wr_en;

  assign has_top  = (count_q != '0);
  assign has_sub  = (count_q > CW'(1));
  assign full     = (count_q == CW'(STACK_DEPTH));
  assign top_prec = prec_of(top_q);
  assign sub_prec = prec_of(sub_q);
  assign out_free = !ovalid_q || !out_stall_i;

  always_comb begin
    emit     = 1'b0;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    done     = 1'b0;
    res_kind = KIND_OPERAND;
    res_err  = ERR_NONE;
    res_op   = '0;
    res_last = 1'b0;
    case (cmd_i.kind)
      CMD_OPERAND: begin
        emit     = 1'b1;
        res_last = 1'b1;
        done     = 1'b1;
      end
      CMD_OPEN: begin
        done = 1'b1;
        if (full) begin
          emit     = 1'b1;
          res_kind = KIND_ERROR;
          res_err  = ERR_OVERFLOW;
          res_last = 1'b1;
        end else begin
          do_push = 1'b1;
        end
      end
      CMD_BINARY: begin
        if (has_top && top_q != OP_OPEN && top_prec >= cmd_i.prec) begin
          // Last pop when the entry below will not pop; the push then succeeds
          emit     = 1'b1;
          do_pop   = 1'b1;
          res_kind = KIND_OPERATOR;
          res_op   = top_q;
          res_last = !(has_sub && sub_q != OP_OPEN && sub_prec >= cmd_i.prec);
        end else if (full) begin
          emit     = 1'b1;
          res_kind = KIND_ERROR;
          res_err  = ERR_OVERFLOW;
          res_last = 1'b1;
          done     = 1'b1;
        end else begin
          do_push = 1'b1;
          done    = 1'b1;
        end
      end
      CMD_CLOSE: begin
        if (!has_top) begin
          emit     = 1'b1;
          res_kind = KIND_ERROR;
          res_err  = ERR_UNMATCHED;
          res_last = 1'b1;
          done     = 1'b1;
        end else if (top_q == OP_OPEN) begin
          do_pop = 1'b1;
          done   = 1'b1;
        end else begin
          emit     = 1'b1;
          do_pop   = 1'b1;
          res_kind = KIND_OPERATOR;
          res_op   = top_q;
          res_last = has_sub && sub_q == OP_OPEN;
        end
      end
      CMD_END: begin
        if (!has_top) begin
          emit     = 1'b1;
          res_kind = KIND_END;
          res_last = 1'b1;
          done     = 1'b1;
        end else if (top_q == OP_OPEN) begin
          do_pop = 1'b1;
        end else begin
          emit     = 1'b1;
          do_pop   = 1'b1;
          res_kind = KIND_OPERATOR;
          res_op   = top_q;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign step_go   = cmd_valid_i && (!emit || out_free);
  assign load      = step_go && emit;
  assign cmd_pop_o = step_go && done;

  always_comb begin
    count_d = count_q;
    if (step_go && do_push)     count_d = count_q + CW'(1);
    else if (step_go && do_pop) count_d = count_q - CW'(1);
  end

  // Old top spills into the memory on a push; the prefetch address follows the
  // new depth so sub_q is always the entry below the top.
  assign wr_en   = step_go && do_push && has_top;
  assign wr_addr = count_q - CW'(1);
  assign rd_addr = count_d - CW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (load)            ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr[AW-1:0]] <= top_q;
    if (wr_en && wr_addr == rd_addr) sub_q <= top_q;
    else                             sub_q <= mem[rd_addr[AW-1:0]];
    if (step_go && do_push)     top_q <= cmd_i.op;
    else if (step_go && do_pop) top_q <= sub_q;
    if (load) begin
      okind_q  <= res_kind;
      oerr_q   <= res_err;
      oop_q    <= res_op;
      olast_q  <= res_last;
      ovalue_q <= (res_kind == KIND_OPERAND) ? cmd_value_i : '0;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_kind_o   = okind_q;
  assign out_value_o  = ovalue_q;
  assign out_op_o     = oop_q;
  assign error_code_o = oerr_q;
  assign last_o       = olast_q;

  `ITP_ASSERT(a_count_bound, count_q <= CW'(STACK_DEPTH), "stack count above depth")
  `ITP_ASSERT(a_overflow_full, (load && res_err == ERR_OVERFLOW) |-> full, "overflow while not full")
  `ITP_ASSERT(a_unmatched_empty, (load && res_err == ERR_UNMATCHED) |-> !has_top, "unmatched with entries")
  `ITP_ASSERT_NEXT(a_end_empty, load && res_kind == KIND_END, count_q == '0, "stack not empty after end")
  `ITP_ASSERT_NEXT(a_push_count, step_go && do_push, count_q == $past(count_q) + CW'(1), "push lost")

endmodule

>>> rtl/core/infix_to_postfix_converter.sv
// -----------------------------------------------------------------------------
// Infix to postfix converter
// Shunting-yard conversion of an infix token stream into postfix order.
// -----------------------------------------------------------------------------
// Token words enter on the in channel and are classified and queued (two
// entries), so the input keeps flowing while the stack engine works. The engine
// does one stack step per cycle: operands pass, '(' is pushed, an operator pops
// equal or stronger ones above the nearest '(' and is pushed, ')' pops down
// to its '(' and drops it, '#' flushes the stack, dropping any '('. Each word
// yields at most one result per cycle and the final result of a token has last_o
// set; ')' that closes an empty group yields no result. Results leave through
// an output register; stall on the out channel only holds the engine once it
// needs to emit. Stack overflow and a ')' without '(' give an error result.
// -----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = itp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // token words
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic [itp_pkg::FIELD_VALUE_W-1:0]  operand_value_i,
  input  logic [2:0]                         op_code_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         out_kind_o,
  output logic [itp_pkg::FIELD_VALUE_W-1:0]  out_value_o,
  output logic [2:0]                         out_op_o,
  output logic [1:0]                         error_code_o,
  output logic                               last_o
);
  import itp_pkg::*;

  // Operand bits carried internally; anything above is dropped
  localparam int unsigned DW = (VALUE_WIDTH < FIELD_VALUE_W) ? VALUE_WIDTH : FIELD_VALUE_W;

  logic          q_push, q_full, q_valid, q_pop;
  cmd_t          f_cmd, h_cmd;
  logic [DW-1:0] f_value, h_value, o_value;

  itp_front #(
    .DATA_W (DW)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .value_i    (operand_value_i[DW-1:0]),
    .op_code_i  (op_code_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (f_cmd),
    .q_value_o  (f_value)
  );

  itp_queue #(
    .DATA_W (DW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_cmd_i   (f_cmd),
    .push_value_i (f_value),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_cmd_o   (h_cmd),
    .head_value_o (h_value)
  );

  itp_back #(
    .DATA_W      (DW),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (h_cmd),
    .cmd_value_i  (h_value),
    .cmd_pop_o    (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_kind_o   (out_kind_o),
    .out_value_o  (o_value),
    .out_op_o     (out_op_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

  assign out_value_o = FIELD_VALUE_W'(o_value);

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Infix to postfix converter testbench
// Token words in, postfix words out, checked against an in-bench shunting yard.
// -----------------------------------------------------------------------------
// An initial block builds the whole token list up front. It starts with a
// short directed set of expressions, then adds random content: well-formed
// expressions, deep nests that overflow the operator stack, broken sequences
// and loose noise tokens. A negedge driver offers the tokens with random gaps.
// A negedge process drives out stall, including one long hold-off that backs
// the block up into its input. The posedge monitor runs every accepted token
// through a local operator stack and compares each accepted result word,
// field by field, with the oldest expected word.
// -----------------------------------------------------------------------------
module tb;
  import itp_pkg::*;

  localparam int unsigned OP_STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned ITEM_TARGET    = 430;
  localparam int unsigned HOLD_AT        = 120;  // tokens accepted before the long hold
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 80;   // a flush pops up to 32 entries

  // Binding strength per op code, zero for codes that never pop
  localparam int BIND_RANK [0:7] = '{2, 2, 1, 1, 0, 0, 0, 3};

  typedef struct {
    logic        typ;
    logic [31:0] val;
    logic [2:0]  op;
  } token_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [2:0]  op;
    logic [1:0]  err;
    logic        last;
  } postfix_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        req_type_i;
  logic [31:0] operand_value_i;
  logic [2:0]  op_code_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  out_kind_o;
  logic [31:0] out_value_o;
  logic [2:0]  out_op_o;
  logic [1:0]  error_code_o;
  logic        last_o;

  token_t        token_q[$];     // tokens still to be offered
  postfix_word_t postfix_q[$];   // result words still owed by the block

  // Local shunting-yard state
  logic [2:0] op_stack [OP_STACK_DEPTH];
  int         op_depth;

  int unsigned accepted_count;   // updated at posedge only
  int unsigned offer_count;      // driver private
  int unsigned fail_count;
  int unsigned in_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;

  infix_to_postfix_converter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .operand_value_i (operand_value_i),
    .op_code_i       (op_code_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_kind_o      (out_kind_o),
    .out_value_o     (out_value_o),
    .out_op_o        (out_op_o),
    .error_code_o    (error_code_o),
    .last_o          (last_o)
  );

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    req_type_i      = REQ_OPERAND;
    operand_value_i = '0;
    op_code_i       = OP_MUL;
    out_stall_i     = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none or short, a few long. Every fourth block of
  // 50 tokens runs with no idling at all on either side.
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (((accepted_count / 50) % 4) == 2) return 0;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_binop();
    case ($urandom_range(0, 4))
      0:       return OP_MUL;
      1:       return OP_DIV;
      2:       return OP_ADD;
      3:       return OP_SUB;
      default: return OP_POW;
    endcase
  endfunction

  task automatic add_operand(input logic [31:0] v);
    token_t t;
    t.typ = REQ_OPERAND;
    t.val = v;
    t.op  = 3'($urandom_range(0, 7));   // don't care field gets random bits
    token_q.push_back(t);
  endtask

  task automatic add_op(input logic [2:0] code);
    token_t t;
    t.typ = REQ_OPERATOR;
    t.val = $urandom;               // don't care field gets random bits
    t.op  = code;
    token_q.push_back(t);
  endtask

  // Well-formed expression with random nesting; sometimes a '(' is left open
  // so the end mark has to drop it during the flush.
  task automatic add_expression(input int unsigned max_terms);
    int unsigned terms;
    int unsigned opened;
    terms  = $urandom_range(1, max_terms);
    opened = 0;
    for (int unsigned i = 0; i < terms; i++) begin
      while (opened < 6 && $urandom_range(0, 3) == 0) begin
        add_op(OP_OPEN);
        opened++;
      end
      add_operand(rand_value());
      while (opened > 0 && $urandom_range(0, 2) == 0) begin
        add_op(OP_CLOSE);
        opened--;
      end
      if (i != terms - 1) add_op(rand_binop());
    end
    if ($urandom_range(0, 7) != 0) begin
      while (opened > 0) begin
        add_op(OP_CLOSE);
        opened--;
      end
    end
    add_op(OP_END);
  endtask

  // Nest of open parens, half of them with an operand and an operator, deep
  // enough to hit the stack limit in most cases.
  task automatic add_deep_nest(input int unsigned levels);
    repeat (levels) begin
      add_op(OP_OPEN);
      if ($urandom_range(0, 1)) begin
        add_operand(rand_value());
        add_op(rand_binop());
      end
    end
    add_operand(rand_value());
    add_op(OP_END);
  endtask

  // Loose tokens with every field random
  task automatic add_noise(input int unsigned count);
    token_t t;
    repeat (count) begin
      t.typ = 1'($urandom_range(0, 1));
      t.val = $urandom;
      t.op  = 3'($urandom_range(0, 7));
      token_q.push_back(t);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Expected postfix words for one token
  // ---------------------------------------------------------------------------
  function automatic postfix_word_t make_word(logic [1:0] kind, logic [31:0] value,
                                              logic [2:0] op, logic [1:0] err);
    postfix_word_t w;
    w.kind  = kind;
    w.value = value;
    w.op    = op;
    w.err   = err;
    w.last  = 1'b0;
    return w;
  endfunction

  task automatic convert_token(input token_t t);
    postfix_word_t words[$];
    logic [2:0]    top;
    bit            matched;
    matched = 1'b0;
    if (t.typ == REQ_OPERAND) begin
      words.push_back(make_word(KIND_OPERAND, t.val, OP_MUL, ERR_NONE));
    end else if (t.op == OP_CLOSE) begin
      // pop to the matching '(' and drop both
      while (op_depth > 0 && !matched) begin
        op_depth--;
        top = op_stack[op_depth];
        if (top == OP_OPEN) matched = 1'b1;
        else words.push_back(make_word(KIND_OPERATOR, '0, top, ERR_NONE));
      end
      if (!matched) words.push_back(make_word(KIND_ERROR, '0, OP_MUL, ERR_UNMATCHED));
    end else if (t.op == OP_END) begin
      // flush; stray '(' vanish silently
      while (op_depth > 0) begin
        op_depth--;
        top = op_stack[op_depth];
        if (top != OP_OPEN) words.push_back(make_word(KIND_OPERATOR, '0, top, ERR_NONE));
      end
      words.push_back(make_word(KIND_END, '0, OP_MUL, ERR_NONE));
    end else begin
      // binary operators pop equal or stronger ones; '(' pops nothing
      if (t.op != OP_OPEN) begin
        while (op_depth > 0 && op_stack[op_depth - 1] != OP_OPEN &&
               BIND_RANK[op_stack[op_depth - 1]] >= BIND_RANK[t.op]) begin
          op_depth--;
          words.push_back(make_word(KIND_OPERATOR, '0, op_stack[op_depth], ERR_NONE));
        end
      end
      if (op_depth >= OP_STACK_DEPTH) begin
        words.push_back(make_word(KIND_ERROR, '0, OP_MUL, ERR_OVERFLOW));
      end else begin
        op_stack[op_depth] = t.op;
        op_depth++;
      end
    end
    if (words.size() > 0) words[words.size() - 1].last = 1'b1;
    foreach (words[i]) postfix_q.push_back(words[i]);
  endtask

  task automatic check_word();
    postfix_word_t w;
    if (postfix_q.size() == 0) begin
      $error("unexpected result word: kind %0d value %h op %0d err %0d last %0d",
             out_kind_o, out_value_o, out_op_o, error_code_o, last_o);
      fail_count++;
    end else begin
      w = postfix_q.pop_front();
      if (out_kind_o !== w.kind) begin
        $error("out_kind mismatch: expected %0d, actual %0d", w.kind, out_kind_o);
        fail_count++;
      end
      if (out_value_o !== w.value) begin
        $error("out_value mismatch: expected %h, actual %h", w.value, out_value_o);
        fail_count++;
      end
      if (out_op_o !== w.op) begin
        $error("out_op mismatch: expected %0d, actual %0d", w.op, out_op_o);
        fail_count++;
      end
      if (error_code_o !== w.err) begin
        $error("error_code mismatch: expected %0d, actual %0d", w.err, error_code_o);
        fail_count++;
      end
      if (last_o !== w.last) begin
        $error("last mismatch: expected %0d, actual %0d", w.last, last_o);
        fail_count++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: hold the word until it is taken, then idle or offer the next.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    token_t t;
    if (rst_ni) begin
      if (in_valid_i && accepted_count != offer_count) begin
        // stalled word stays put
      end else if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (token_q.size() > 0) begin
        t = token_q.pop_front();
        req_type_i      <= t.typ;
        operand_value_i <= t.val;
        op_code_i       <= t.op;
        in_valid_i      <= 1'b1;
        offer_count++;
        in_gap = draw_idle();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random stretches, plus one long hold-off once the run is
  // under way so the internal queue and output register fill up and the
  // block has to stall its input while the driver keeps offering.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && accepted_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = draw_idle();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted tokens, check accepted result words.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    token_t t;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        t.typ = req_type_i;
        t.val = operand_value_i;
        t.op  = op_code_i;
        convert_token(t);
        accepted_count <= accepted_count + 1;
      end
      if (out_valid_o && !out_stall_i) check_word();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned total;
    int unsigned pick;
    op_depth       = 0;
    accepted_count = 0;
    offer_count    = 0;
    fail_count     = 0;
    in_gap         = 0;
    stall_left     = 0;
    hold_left      = 0;
    hold_done      = 1'b0;

    // ')' on an empty stack: error only
    add_op(OP_CLOSE);
    // empty group: no result at all
    add_op(OP_OPEN);
    add_op(OP_CLOSE);
    // 0 * b - c / d ^ e + ffffffff #: every binary operator and the end mark
    add_operand('0);
    add_op(OP_MUL);
    add_operand(32'h0000_0001);
    add_op(OP_SUB);
    add_operand(32'h8000_0000);
    add_op(OP_DIV);
    add_operand(32'h7fff_ffff);
    add_op(OP_POW);
    add_operand(32'h5555_aaaa);
    add_op(OP_ADD);
    add_operand('1);
    add_op(OP_END);
    // '+' left on the stack, then ')' without '(': flush, then error
    add_op(OP_ADD);
    add_op(OP_CLOSE);
    // ( a + b ) * ( c #: matched group, then a '(' dropped at the end mark
    add_op(OP_OPEN);
    add_operand(32'haaaa_5555);
    add_op(OP_ADD);
    add_operand(32'h1234_5678);
    add_op(OP_CLOSE);
    add_op(OP_MUL);
    add_op(OP_OPEN);
    add_operand(32'hdead_beef);
    add_op(OP_END);

    // one guaranteed stack overflow before the random mix
    add_deep_nest(34);

    while (token_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_expression(8);
      end else if (pick < 78) begin
        add_deep_nest($urandom_range(18, 40));
      end else if (pick < 90) begin
        // broken sequence: stray tokens ahead of an expression
        add_noise($urandom_range(1, 3));
        if ($urandom_range(0, 1)) add_op(OP_CLOSE);
        add_expression(5);
      end else begin
        add_noise($urandom_range(1, 5));
      end
    end
    total = token_q.size();

    wait (rst_ni);
    while (accepted_count != total || postfix_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("infix_to_postfix_converter test passed");
    end else begin
      $display("infix_to_postfix_converter test failed");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("infix_to_postfix_converter test failed");
    $finish;
  end

endmodule
